[rtl/mbps_pkg.sv]
package mbps_pkg;

  localparam int MAX_PATTERN_DEF  = 64;
  localparam int ADDRESS_BITS_DEF = 32;

  localparam int LEN_CFG_W = 7;
  localparam int OFFSET_W  = 8;
  localparam int BASE_W    = 32;
  localparam int POS_W     = 32;
  localparam int ENTRY_W   = 6;
  localparam int BYTE_W    = 8;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SCAN = 1'b1;

  // register word indexes
  localparam logic [1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [1:0] REG_RESULT_OFFSET  = 2'd1;
  localparam logic [1:0] REG_REGION_BASE    = 2'd2;

  localparam logic [LEN_CFG_W-1:0] PATTERN_LENGTH_RST = 7'd1;

  typedef struct packed {
    logic [LEN_CFG_W-1:0] pattern_length;
    logic [OFFSET_W-1:0]  result_offset;
    logic [BASE_W-1:0]    region_base;
  } cfg_t;

  typedef struct packed {
    logic update;  // advance the match bit
    logic clear;   // region end: drop the match bit
  } scan_ctl_t;

endpackage

[rtl/masked_byte_pattern_search.sv]
// Masked byte pattern search.
// Pattern entries are loaded through the item channel (command = load) with a
// byte and a must-match mark; entry 0 always compares exactly. Scan items
// (command = scan) carry one data byte each; last_byte closes the region.
// Each pattern entry lives in one cell of a chain; a cell compares its entry
// with the broadcast data byte and passes its partial-match bit to the next.
// The first full match of a region gives one result transfer: found = 1 and
// match_address = region_base + match start + result_offset. A region that
// ends unmatched gives found = 0, address 0. Other items give no result.
// Throughput: one item per cycle, loads and scans alike, while item_stall is low.
// A result is registered onto the result port, or into the skid entry if busy.
// Results queue in a two-entry output buffer; item_stall rises while both
// entries hold results and drops the cycle after the receiver takes one.
// Reset clears registers (pattern_length 1), partial matches, the byte
// position and the buffer; pattern entries hold garbage until loaded.
// Write registers only while no item is in flight; the block does not enforce it.
module masked_byte_pattern_search #(
  parameter int MAX_PATTERN  = mbps_pkg::MAX_PATTERN_DEF,
  parameter int ADDRESS_BITS = mbps_pkg::ADDRESS_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mbps_pkg::PADDR_W-1:0]     paddr,
  input  logic [mbps_pkg::PDATA_W-1:0]     pwdata,
  output logic [mbps_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic                             command,
  input  logic [mbps_pkg::ENTRY_W-1:0]     entry_index,
  input  logic [mbps_pkg::BYTE_W-1:0]      byte_value,
  input  logic                             must_match,
  input  logic                             last_byte,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic                             found,
  output logic [ADDRESS_BITS-1:0]          match_address
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = $clog2(MAX_PATTERN);
  localparam int CMP_W = (LEN_W > mbps_pkg::LEN_CFG_W) ? LEN_W : mbps_pkg::LEN_CFG_W;
  localparam int SUM_W = (ADDRESS_BITS > 34) ? ADDRESS_BITS : 34;

  mbps_pkg::cfg_t      cfg;
  mbps_pkg::scan_ctl_t ctl;

  logic                        accept;
  logic                        load_acc;
  logic                        scan_acc;
  logic [CMP_W-1:0]            len_raw;
  logic [LEN_W-1:0]            len_eff;
  logic [IDX_W-1:0]            last_idx;
  logic [MAX_PATTERN-1:0]      match;
  logic [MAX_PATTERN-1:0]      match_next;
  logic [mbps_pkg::POS_W-1:0]  byte_position;
  logic [mbps_pkg::POS_W-1:0]  start;
  logic [SUM_W-1:0]            sum;
  logic                        region_done;
  logic                        hit;
  logic                        push;
  logic                        buf_full;

  mbps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign item_stall = buf_full;
  assign accept     = item_valid && !item_stall;
  assign load_acc   = accept && (command == mbps_pkg::CMD_LOAD);
  assign scan_acc   = accept && (command == mbps_pkg::CMD_SCAN);

  // clamp length into 1..MAX_PATTERN
  always_comb begin
    len_raw = CMP_W'(cfg.pattern_length);
    if (len_raw == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_raw > CMP_W'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = LEN_W'(len_raw);
    end
  end

  assign last_idx   = IDX_W'(len_eff - LEN_W'(1));
  assign ctl.update = scan_acc && !region_done;
  assign ctl.clear  = scan_acc && last_byte;

  for (genvar e = 0; e < MAX_PATTERN; e++) begin : g_cell
    mbps_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .load_sel   (load_acc && (int'(entry_index) == e)),
      .load_byte  (byte_value),
      .load_care  (must_match),
      .exact      (e == 0),
      .active     (int'(len_eff) > e),
      .ctl        (ctl),
      .scan_byte  (byte_value),
      .prev_match ((e == 0) ? 1'b1 : match[(e == 0) ? 0 : e - 1]),
      .match      (match[e]),
      .match_next (match_next[e])
    );
  end

  assign hit   = ctl.update && match_next[last_idx];
  assign start = byte_position - mbps_pkg::POS_W'(len_eff - LEN_W'(1));
  assign sum   = SUM_W'(cfg.region_base) + SUM_W'(start) + SUM_W'(cfg.result_offset);
  assign push  = hit || (ctl.update && last_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      region_done   <= 1'b0;
    end else if (scan_acc) begin
      if (last_byte) begin
        byte_position <= '0;
        region_done   <= 1'b0;
      end else if (!region_done) begin
        byte_position <= byte_position + mbps_pkg::POS_W'(1);
        region_done   <= hit;
      end
    end
  end

  mbps_out_buf #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_out_buf (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .push_found    (hit),
    .push_addr     (hit ? sum[ADDRESS_BITS-1:0] : '0),
    .full          (buf_full),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .found         (found),
    .match_address (match_address)
  );

endmodule

[rtl/mbps_regs.sv]
module mbps_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mbps_pkg::PADDR_W-1:0]    paddr,
  input  logic [mbps_pkg::PDATA_W-1:0]    pwdata,
  output logic [mbps_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  output mbps_pkg::cfg_t                  cfg
);

  logic       wr_en;
  logic [1:0] word;

  assign pready = 1'b1;
  assign word   = paddr[3:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_length <= mbps_pkg::PATTERN_LENGTH_RST;
      cfg.result_offset  <= '0;
      cfg.region_base    <= '0;
    end else if (wr_en) begin
      unique case (word)
        mbps_pkg::REG_PATTERN_LENGTH: begin
          cfg.pattern_length <= pwdata[mbps_pkg::LEN_CFG_W-1:0];
        end
        mbps_pkg::REG_RESULT_OFFSET: begin
          cfg.result_offset <= pwdata[mbps_pkg::OFFSET_W-1:0];
        end
        mbps_pkg::REG_REGION_BASE: begin
          cfg.region_base <= pwdata[mbps_pkg::BASE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (word)
      mbps_pkg::REG_PATTERN_LENGTH: begin
        prdata = mbps_pkg::PDATA_W'(cfg.pattern_length);
      end
      mbps_pkg::REG_RESULT_OFFSET: begin
        prdata = mbps_pkg::PDATA_W'(cfg.result_offset);
      end
      mbps_pkg::REG_REGION_BASE: begin
        prdata = mbps_pkg::PDATA_W'(cfg.region_base);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

[rtl/mbps_cell.sv]
module mbps_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load_sel,
  input  logic [mbps_pkg::BYTE_W-1:0]    load_byte,
  input  logic                           load_care,
  input  logic                           exact,      // ignore the wildcard mark
  input  logic                           active,     // entry lies inside the pattern
  input  mbps_pkg::scan_ctl_t            ctl,
  input  logic [mbps_pkg::BYTE_W-1:0]    scan_byte,
  input  logic                           prev_match,
  output logic                           match,
  output logic                           match_next
);

  logic [mbps_pkg::BYTE_W-1:0] pat;
  logic                        care;
  logic                        eq;

  always_ff @(posedge clk) begin
    if (load_sel) begin
      pat  <= load_byte;
      care <= load_care;
    end
  end

  assign eq         = active && ((!care && !exact) || (pat == scan_byte));
  assign match_next = prev_match && eq;

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctl.clear) begin
      match <= 1'b0;
    end else if (ctl.update) begin
      match <= match_next;
    end
  end

endmodule

[rtl/mbps_out_buf.sv]
module mbps_out_buf #(
  parameter int ADDRESS_BITS = mbps_pkg::ADDRESS_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic                    push_found,
  input  logic [ADDRESS_BITS-1:0] push_addr,
  output logic                    full,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic                    found,
  output logic [ADDRESS_BITS-1:0] match_address
);

  logic                    skid_valid;
  logic                    skid_found;
  logic [ADDRESS_BITS-1:0] skid_addr;
  logic                    pop;

  assign pop  = result_valid && !result_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (result_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        result_valid <= 1'b1;
      end
    end else if (pop) begin
      result_valid <= 1'b0;
    end
  end

  // payload side, no reset
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        found         <= skid_found;
        match_address <= skid_addr;
      end
    end else if (push) begin
      if (result_valid && !pop) begin
        skid_found <= push_found;
        skid_addr  <= push_addr;
      end else begin
        found         <= push_found;
        match_address <= push_addr;
      end
    end
  end

endmodule
